>>> src/kmd_pkg.sv
`timescale 1ns / 1ps

package kmd_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_MOUSE      = 2'd0,
    OP_KEY        = 2'd1,
    OP_FRAME_END  = 2'd2,
    OP_CLEAR_PEND = 2'd3
  } op_t;

  // Key action codes.
  localparam logic [1:0] ACT_RELEASED = 2'd0;
  localparam logic [1:0] ACT_PRESSED  = 2'd1;
  localparam logic [1:0] ACT_HELD     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CAPSLOCK_CODE = 3'd2;
  localparam logic [2:0] REG_LSHIFT_CODE   = 3'd3;
  localparam logic [2:0] REG_RSHIFT_CODE   = 3'd4;

  // Configuration reset values.
  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [7:0]  CAPSLOCK_CODE_RST = 8'd58;
  localparam logic [7:0]  LSHIFT_CODE_RST   = 8'd42;
  localparam logic [7:0]  RSHIFT_CODE_RST   = 8'd54;

  // Pointer position after reset.
  localparam int unsigned POS_RST = 100;

  // Lowercase letter range in ASCII.
  localparam logic [6:0] ASCII_LO_A = 7'h61;
  localparam logic [6:0] ASCII_LO_Z = 7'h7a;

  // Set-1 translation tables.
  localparam int unsigned ROM_SIZE = 90;

  localparam logic [6:0] ROM_PLAIN [ROM_SIZE] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] ROM_SHIFTED [ROM_SIZE] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h2d, 7'h00, 7'h00, 7'h00, 7'h2b, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Classified item as it travels from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic [2:0] buttons;
    logic [7:0] scan_code;
    logic       key_ok;      // keyboard item with a scancode inside the key table
    logic       press_hold;  // action is pressed or held
    logic       caps_hit;    // press of the caps lock code
    logic       is_letter;   // plain translation is a lowercase letter
    logic [6:0] plain_char;
    logic [6:0] shift_char;
  } item_t;

  // Shift code reload request from the configuration port.
  typedef struct packed {
    logic       load_left;
    logic       load_right;
    logic [7:0] code;
  } shift_cfg_t;

  function automatic logic [6:0] rom_plain_read(input logic [7:0] code);
    if (code < 8'(ROM_SIZE)) return ROM_PLAIN[code[6:0]];
    return 7'd0;
  endfunction

  function automatic logic [6:0] rom_shifted_read(input logic [7:0] code);
    if (code < 8'(ROM_SIZE)) return ROM_SHIFTED[code[6:0]];
    return 7'd0;
  endfunction

endpackage

>>> src/keyboard_mouse_event_decoder.sv
`timescale 1ns / 1ps

// Keyboard and mouse event decoder.
// Input channel in_*: one event per transfer; in_tuser selects mouse, keyboard,
// frame end or clear pending, and in_tdata carries position, buttons and key fields.
// Output channel out_*: exactly one result per accepted event, in order, giving
// the pointer, buttons, translated character, last key and the frame flags.
// Configuration port cfg_*: screen size and the caps lock and shift scancodes,
// written while no event is in flight; each write takes effect once registered.
// An event passes the queue and then the output register. One event per cycle is
// sustained while the receiver does not stall and no clearing pass runs: the front
// end clamps and looks up the translation tables, a two-entry queue decouples it
// from the back end, which updates the state and loads the output register.
// Reset clears the pointer to (100, 100), all buttons, flags and keys, and
// loads the default configuration. The key table is then released by a
// clearing pass over all KEY_COUNT entries (256 by default); events are queued
// meanwhile and their results follow once the pass ends. When the receiver
// stalls, the result waits in the output register and the queue absorbs up
// to two more events before in_tready falls.
module keyboard_mouse_event_decoder
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT  = 256,
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // raw_x[15:0], raw_y[31:16], button_bits[34:32], scan_code[42:35],
  // key_action[44:43], zero[47:45]
  input  logic [47:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pointer_x[11:0], pointer_y[23:12], left_down[24], right_down[25],
  // middle_down[26], char_valid[27], char_code[34:28], last_key[42:35],
  // frame_left_click[43], frame_right_click[44], input_changed[45], zero[47:46]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  localparam int ENTRY_W = 2 * COORD_BITS + $bits(item_t);

  logic [12:0]           screen_width_r;
  logic [12:0]           screen_height_r;
  logic [7:0]            capslock_code_r;
  logic [7:0]            lshift_code_r;
  logic [7:0]            rshift_code_r;
  shift_cfg_t            shift_cfg;
  logic [COORD_BITS-1:0] f_x, f_y, q_x, q_y;
  item_t                 f_item, q_item;
  logic [ENTRY_W-1:0]    q_data;
  logic                  q_valid, q_pop;
  logic                  in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      capslock_code_r <= CAPSLOCK_CODE_RST;
      lshift_code_r   <= LSHIFT_CODE_RST;
      rshift_code_r   <= RSHIFT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        REG_CAPSLOCK_CODE: capslock_code_r <= cfg_wdata[7:0];
        REG_LSHIFT_CODE:   lshift_code_r   <= cfg_wdata[7:0];
        REG_RSHIFT_CODE:   rshift_code_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Shift code writes also refresh the back end's shift key mirrors.
  always_comb begin
    shift_cfg.load_left  = cfg_we && (cfg_addr == REG_LSHIFT_CODE);
    shift_cfg.load_right = cfg_we && (cfg_addr == REG_RSHIFT_CODE);
    shift_cfg.code       = cfg_wdata[7:0];
  end

  kmd_front #(
    .KEY_COUNT  (KEY_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .op            (op_t'(in_tuser)),
    .raw_x         (in_tdata[15:0]),
    .raw_y         (in_tdata[31:16]),
    .button_bits   (in_tdata[34:32]),
    .scan_code     (in_tdata[42:35]),
    .key_action    (in_tdata[44:43]),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .capslock_code (capslock_code_r),
    .clamp_x       (f_x),
    .clamp_y       (f_y),
    .item          (f_item)
  );

  kmd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data ({f_x, f_y, f_item}),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign {q_x, q_y, q_item} = q_data;

  kmd_back #(
    .KEY_COUNT  (KEY_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_pop       (q_pop),
    .lshift_code (lshift_code_r),
    .rshift_code (rshift_code_r),
    .shift_cfg   (shift_cfg),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

>>> src/kmd_front.sv
`timescale 1ns / 1ps

module kmd_front
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT  = 256,
  parameter int COORD_BITS = 12
) (
  input  op_t                   op,
  input  logic [15:0]           raw_x,
  input  logic [15:0]           raw_y,
  input  logic [2:0]            button_bits,
  input  logic [7:0]            scan_code,
  input  logic [1:0]            key_action,
  input  logic [12:0]           screen_width,
  input  logic [12:0]           screen_height,
  input  logic [7:0]            capslock_code,
  output logic [COORD_BITS-1:0] clamp_x,
  output logic [COORD_BITS-1:0] clamp_y,
  output item_t                 item
);

  // Compare width: holds a 15-bit magnitude and the limit 1 << COORD_BITS.
  localparam int CW = (COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16;

  // Clamp a signed coordinate to 0 .. size-1, with size forced into 1 .. 2^COORD_BITS.
  function automatic logic [COORD_BITS-1:0] clamp(input logic [15:0] raw,
                                                  input logic [12:0] size);
    logic [CW-1:0] lim;
    logic [CW-1:0] mag;
    logic [CW-1:0] maxc;
    maxc = CW'(1) << COORD_BITS;
    mag  = CW'(raw[14:0]);
    lim  = CW'(size);
    if (lim == '0) lim = CW'(1);
    if (lim > maxc) lim = maxc;
    if (raw[15]) return '0;
    if (mag >= lim) return COORD_BITS'(lim - CW'(1));
    return COORD_BITS'(mag);
  endfunction

  logic [6:0] plain_char;
  logic       press_hold;

  // Coordinate clamping.
  assign clamp_x = clamp(raw_x, screen_width);
  assign clamp_y = clamp(raw_y, screen_height);

  // Key classification and table lookup.
  assign plain_char = rom_plain_read(scan_code);
  assign press_hold = (key_action == ACT_PRESSED) || (key_action == ACT_HELD);

  always_comb begin
    item.op         = op;
    item.buttons    = button_bits;
    item.scan_code  = scan_code;
    item.key_ok     = (op == OP_KEY) && ({1'b0, scan_code} < 9'(KEY_COUNT));
    item.press_hold = press_hold;
    item.caps_hit   = (key_action == ACT_PRESSED) && (scan_code == capslock_code);
    item.is_letter  = plain_char inside {[ASCII_LO_A:ASCII_LO_Z]};
    item.plain_char = plain_char;
    item.shift_char = rom_shifted_read(scan_code);
  end

endmodule

>>> src/kmd_queue.sv
`timescale 1ns / 1ps

module kmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  // Two-entry queue between the front end and the back end.
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage is written on every push transfer.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> src/kmd_back.sv
`timescale 1ns / 1ps

module kmd_back
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT  = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  item_t                 q_item,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  output logic                  q_pop,
  input  logic [7:0]            lshift_code,
  input  logic [7:0]            rshift_code,
  input  shift_cfg_t            shift_cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [47:0]           out_data
);

  localparam int KEY_BITS = $clog2(KEY_COUNT);

  // Pointer and button state.
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [2:0]            buttons_r, buttons_nxt;
  logic [1:0]            click_latch_r, click_latch_nxt;
  logic [1:0]            frame_clicks_r, frame_clicks_nxt;
  logic                  changed_r, changed_nxt;
  logic                  pending_r, pending_nxt;

  // Keyboard state. The table keeps only whether each key is down.
  logic                  key_down_r [KEY_COUNT];
  logic                  key_rd_r;
  logic                  load_left_r;
  logic                  load_right_r;
  logic                  clr_busy_r;
  logic [KEY_BITS-1:0]   clr_idx_r;
  logic                  lshift_dn_r, lshift_dn_nxt;
  logic                  rshift_dn_r, rshift_dn_nxt;
  logic                  shift_r, shift_nxt;
  logic                  caps_r, caps_nxt;
  logic [7:0]            recent_key_r, recent_key_nxt;

  logic                  fire;
  logic                  char_valid;
  logic [6:0]            char_code;
  logic                  use_shift;
  logic                  cfg_in_range;
  logic                  out_valid_r;
  logic [47:0]           out_data_r;

  // An item retires when the key table is ready and the output register is
  // free or being drained.
  assign fire      = q_valid && !clr_busy_r && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // State update for the item at the head of the queue.
  always_comb begin
    pos_x_nxt        = pos_x_r;
    pos_y_nxt        = pos_y_r;
    buttons_nxt      = buttons_r;
    click_latch_nxt  = click_latch_r;
    frame_clicks_nxt = frame_clicks_r;
    changed_nxt      = changed_r;
    pending_nxt      = pending_r;
    lshift_dn_nxt    = lshift_dn_r;
    rshift_dn_nxt    = rshift_dn_r;
    shift_nxt        = shift_r;
    caps_nxt         = caps_r;
    recent_key_nxt   = recent_key_r;
    char_valid       = 1'b0;
    char_code        = 7'd0;
    use_shift        = shift_r;
    case (q_item.op)
      OP_MOUSE: begin
        if ((q_x != pos_x_r) || (q_y != pos_y_r) || (q_item.buttons != buttons_r)) begin
          changed_nxt = 1'b1;
        end
        click_latch_nxt = click_latch_r | (q_item.buttons[1:0] & ~buttons_r[1:0]);
        pos_x_nxt       = q_x;
        pos_y_nxt       = q_y;
        buttons_nxt     = q_item.buttons;
      end
      OP_KEY: begin
        if (q_item.key_ok) begin
          changed_nxt = 1'b1;
          caps_nxt    = caps_r ^ q_item.caps_hit;
          if (q_item.press_hold) begin
            recent_key_nxt = q_item.scan_code;
            if (q_item.is_letter) use_shift = shift_r ^ caps_nxt;
            char_code  = use_shift ? q_item.shift_char : q_item.plain_char;
            char_valid = 1'b1;
          end
          // Shift keys track the table entry just written.
          if (q_item.scan_code == lshift_code) lshift_dn_nxt = q_item.press_hold;
          if (q_item.scan_code == rshift_code) rshift_dn_nxt = q_item.press_hold;
          shift_nxt = lshift_dn_nxt || rshift_dn_nxt;
        end
      end
      OP_FRAME_END: begin
        frame_clicks_nxt = click_latch_r;
        click_latch_nxt  = 2'd0;
        pending_nxt      = changed_r;
        changed_nxt      = 1'b0;
        recent_key_nxt   = 8'd0;
      end
      OP_CLEAR_PEND: begin
        pending_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  assign cfg_in_range = ({1'b0, shift_cfg.code} < 9'(KEY_COUNT));

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r        <= COORD_BITS'(POS_RST);
      pos_y_r        <= COORD_BITS'(POS_RST);
      buttons_r      <= 3'd0;
      click_latch_r  <= 2'd0;
      frame_clicks_r <= 2'd0;
      changed_r      <= 1'b0;
      pending_r      <= 1'b0;
      lshift_dn_r    <= 1'b0;
      rshift_dn_r    <= 1'b0;
      shift_r        <= 1'b0;
      caps_r         <= 1'b0;
      recent_key_r   <= 8'd0;
      out_valid_r    <= 1'b0;
      load_left_r    <= 1'b0;
      load_right_r   <= 1'b0;
    end else begin
      if (fire) begin
        pos_x_r        <= pos_x_nxt;
        pos_y_r        <= pos_y_nxt;
        buttons_r      <= buttons_nxt;
        click_latch_r  <= click_latch_nxt;
        frame_clicks_r <= frame_clicks_nxt;
        changed_r      <= changed_nxt;
        pending_r      <= pending_nxt;
        lshift_dn_r    <= lshift_dn_nxt;
        rshift_dn_r    <= rshift_dn_nxt;
        shift_r        <= shift_nxt;
        caps_r         <= caps_nxt;
        recent_key_r   <= recent_key_nxt;
      end
      // A new shift code reloads its mirror from the key table once the table read
      // at that code has been registered.
      load_left_r  <= shift_cfg.load_left;
      load_right_r <= shift_cfg.load_right;
      if (load_left_r) lshift_dn_r <= key_rd_r;
      if (load_right_r) rshift_dn_r <= key_rd_r;
      if (!out_valid_r || out_ready) out_valid_r <= q_valid && !clr_busy_r;
    end
  end

  // Clearing pass after reset: one table entry is released per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_busy_r <= (clr_idx_r != KEY_BITS'(KEY_COUNT - 1));
      clr_idx_r  <= clr_idx_r + KEY_BITS'(1);
    end
  end

  // Key table: one write per cycle, and a registered read at the shift code
  // being configured. Entries not yet cleared read as released.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      key_down_r[clr_idx_r] <= 1'b0;
    end else if (fire && q_item.key_ok) begin
      key_down_r[q_item.scan_code[KEY_BITS-1:0]] <= q_item.press_hold;
    end
    key_rd_r <= cfg_in_range && !clr_busy_r &&
                key_down_r[shift_cfg.code[KEY_BITS-1:0]];
  end

  // Result register, loaded from the state after the update.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {2'd0, pending_nxt, frame_clicks_nxt[1], frame_clicks_nxt[0],
                     recent_key_nxt, char_code, char_valid, buttons_nxt[2],
                     buttons_nxt[1], buttons_nxt[0], 12'(pos_y_nxt),
                     12'(pos_x_nxt)};
    end
  end

endmodule

>>> src/kmd_checker.sv
`timescale 1ns / 1ps

module kmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // Events accepted whose results have not yet been transferred out.
  logic [2:0] outstanding_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= 3'd0;
    end else begin
      case ({in_tvalid && in_tready, out_tvalid && out_tready})
        2'b10:   outstanding_r <= outstanding_r + 3'd1;
        2'b01:   outstanding_r <= outstanding_r - 3'd1;
        default: ;
      endcase
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // No result appears without an accepted event behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> outstanding_r != 3'd0)
    else $error("result without a pending event");

  // The queue and output register together hold at most three events.
  assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= 3'd3)
    else $error("more events in flight than storage allows");

  // Reset empties the output.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keyboard_mouse_event_decoder kmd_checker u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/kmd_event_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the event decoder,
// predicts one report per accepted event and compares each result transfer
// with the oldest outstanding prediction.
module kmd_event_checker
  import kmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  localparam int SCREEN_SPAN = 4096;

  // Set-1 scancode translation, unshifted and shifted.
  localparam logic [6:0] PLAIN_MAP [90] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_MAP [90] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h2d, 7'h00, 7'h00, 7'h00, 7'h2b, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        left;
    logic        right;
    logic        middle;
    logic        cvalid;
    logic [6:0]  ccode;
    logic [7:0]  lkey;
    logic        lclick;
    logic        rclick;
    logic        pend;
  } report_t;

  // Configuration copy.
  logic [12:0] scr_w, scr_h;
  logic [7:0]  caps_sc, lshift_sc, rshift_sc;

  // Decoder state copy.
  logic [11:0] ptr_x, ptr_y;
  logic [2:0]  btn_now;
  logic [1:0]  click_acc, clicks_pub;
  logic        dirty, pend_pub, shift_on, caps_on;
  logic [7:0]  last_sc;
  logic [1:0]  key_state [256];

  report_t pending_reports[$];
  int      fail_total = 0;

  function automatic logic [11:0] clamp_to_screen(input logic signed [15:0] raw,
                                                  input logic [12:0] size);
    int lim;
    lim = (size == 13'd0) ? 1 : int'(size);
    if (lim > SCREEN_SPAN) lim = SCREEN_SPAN;
    if (raw < 0) return '0;
    if (int'(raw) >= lim) return 12'(lim - 1);
    return raw[11:0];
  endfunction

  function automatic logic [6:0] translate(input logic [7:0] code, input logic shifted);
    if (code >= 8'd90) return 7'd0;
    return shifted ? SHIFT_MAP[code] : PLAIN_MAP[code];
  endfunction

  function automatic logic key_is_down(input logic [7:0] code);
    return key_state[code] == ACT_PRESSED || key_state[code] == ACT_HELD;
  endfunction

  // Update the state copy with one event and queue the report it produces.
  task automatic decode_event(input op_t op, input logic [47:0] d);
    logic [11:0] nx, ny;
    logic [2:0]  nb;
    logic [7:0]  sc;
    logic [1:0]  act;
    logic [6:0]  base;
    logic        use_shift;
    report_t     rep;
    rep = '0;
    case (op)
      OP_MOUSE: begin
        nx = clamp_to_screen(d[15:0], scr_w);
        ny = clamp_to_screen(d[31:16], scr_h);
        nb = d[34:32];
        if (nx != ptr_x || ny != ptr_y || nb != btn_now) dirty = 1'b1;
        click_acc = click_acc | (nb[1:0] & ~btn_now[1:0]);
        ptr_x = nx;
        ptr_y = ny;
        btn_now = nb;
      end
      OP_KEY: begin
        sc = d[42:35];
        act = d[44:43];
        key_state[sc] = act;
        dirty = 1'b1;
        if (act == ACT_PRESSED && sc == caps_sc) caps_on = ~caps_on;
        // Letters follow shift XOR caps lock; everything else follows shift.
        if (act == ACT_PRESSED || act == ACT_HELD) begin
          base = translate(sc, 1'b0);
          use_shift = shift_on;
          if (base >= ASCII_LO_A && base <= ASCII_LO_Z) use_shift = shift_on ^ caps_on;
          last_sc = sc;
          rep.cvalid = 1'b1;
          rep.ccode = use_shift ? translate(sc, 1'b1) : base;
        end
        shift_on = key_is_down(lshift_sc) || key_is_down(rshift_sc);
      end
      OP_FRAME_END: begin
        clicks_pub = click_acc;
        click_acc = '0;
        pend_pub = dirty;
        dirty = 1'b0;
        last_sc = '0;
      end
      OP_CLEAR_PEND: begin
        pend_pub = 1'b0;
      end
      default: ;
    endcase
    rep.px = ptr_x;
    rep.py = ptr_y;
    rep.left = btn_now[0];
    rep.right = btn_now[1];
    rep.middle = btn_now[2];
    rep.lkey = last_sc;
    rep.lclick = clicks_pub[0];
    rep.rclick = clicks_pub[1];
    rep.pend = pend_pub;
    pending_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic [11:0] exp_val,
                             input logic [11:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    report_t exp_rep;
    if (!rst_n) begin
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
      caps_sc = CAPSLOCK_CODE_RST;
      lshift_sc = LSHIFT_CODE_RST;
      rshift_sc = RSHIFT_CODE_RST;
      ptr_x = 12'(POS_RST);
      ptr_y = 12'(POS_RST);
      btn_now = '0;
      click_acc = '0;
      clicks_pub = '0;
      dirty = 1'b0;
      pend_pub = 1'b0;
      shift_on = 1'b0;
      caps_on = 1'b0;
      last_sc = '0;
      foreach (key_state[i]) key_state[i] = ACT_RELEASED;
      pending_reports.delete();
    end else begin
      // Register writes take effect for the next event.
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  scr_w = cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h = cfg_wdata;
          REG_CAPSLOCK_CODE: caps_sc = cfg_wdata[7:0];
          REG_LSHIFT_CODE:   lshift_sc = cfg_wdata[7:0];
          REG_RSHIFT_CODE:   rshift_sc = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_event(op_t'(in_tuser), in_tdata);
      // Each result transfer is matched against the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no event outstanding: %h", out_tdata);
          fail_total++;
        end else begin
          exp_rep = pending_reports.pop_front();
          check_field("pointer_x", exp_rep.px, out_tdata[11:0]);
          check_field("pointer_y", exp_rep.py, out_tdata[23:12]);
          check_field("left_down", 12'(exp_rep.left), 12'(out_tdata[24]));
          check_field("right_down", 12'(exp_rep.right), 12'(out_tdata[25]));
          check_field("middle_down", 12'(exp_rep.middle), 12'(out_tdata[26]));
          check_field("char_valid", 12'(exp_rep.cvalid), 12'(out_tdata[27]));
          check_field("char_code", 12'(exp_rep.ccode), 12'(out_tdata[34:28]));
          check_field("last_key", 12'(exp_rep.lkey), 12'(out_tdata[42:35]));
          check_field("frame_left_click", 12'(exp_rep.lclick), 12'(out_tdata[43]));
          check_field("frame_right_click", 12'(exp_rep.rclick), 12'(out_tdata[44]));
          check_field("input_changed", 12'(exp_rep.pend), 12'(out_tdata[45]));
        end
      end
    end
    mismatch_count <= fail_total;
    results_owed <= pending_reports.size();
  end

endmodule

>>> tb/tb_keyboard_mouse_event_decoder.sv
`timescale 1ns / 1ps

module tb_keyboard_mouse_event_decoder
  import kmd_pkg::*;
();

  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 190;

  // Action code that is stored but is neither a press nor a hold.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [12:0] cfg_wdata;

  int unsigned mismatch_count;
  int unsigned results_owed;

  int   cycle_cnt = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int   hold_cnt = 0;

  // Current settings, kept to aim the random scancodes and coordinates.
  logic [12:0] width_sel, height_sel;
  logic [7:0]  caps_sel, lshift_sel, rshift_sel;

  keyboard_mouse_event_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  kmd_event_checker u_event_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    out_tready <= (hold_go || hold_cnt > 1) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [47:0] mouse_payload(input logic [15:0] x, input logic [15:0] y,
                                                input logic [2:0] btn);
    return {3'b000, 2'($urandom), 8'($urandom), btn, y, x};
  endfunction

  function automatic logic [47:0] key_payload(input logic [7:0] sc, input logic [1:0] act);
    return {3'b000, act, sc, 3'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic [47:0] noise_payload();
    return {3'b000, 45'({$urandom, $urandom})};
  endfunction

  // Mostly within the screen and 20 beyond its edges, sometimes anywhere in the signed range.
  function automatic logic [15:0] pick_coord(input logic [12:0] size);
    int r;
    r = $urandom_range(9);
    if (r < 2) return 16'($urandom);
    if (r == 2) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    return 16'(int'($urandom_range(int'(size) + 40)) - 20);
  endfunction

  function automatic logic [7:0] pick_scan();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(53, 16));
    if (r < 47) return caps_sel;
    if (r < 53) return lshift_sel;
    if (r < 58) return rshift_sel;
    if (r < 68) return 8'($urandom_range(89, 0));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ACT_PRESSED;
    if (r < 68) return ACT_HELD;
    if (r < 93) return ACT_RELEASED;
    return ACT_UNUSED;
  endfunction

  // One input transfer, preceded by random idle cycles.
  task automatic push_event(input op_t op, input logic [47:0] payload);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_key(input logic [7:0] sc, input logic [1:0] act);
    push_event(OP_KEY, key_payload(sc, act));
  endtask

  task automatic push_mouse(input logic [15:0] x, input logic [15:0] y, input logic [2:0] btn);
    push_event(OP_MOUSE, mouse_payload(x, y, btn));
  endtask

  // Stop offering events until every result has come back, then settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [12:0] w, input logic [12:0] h,
                               input logic [7:0] caps, input logic [7:0] ls,
                               input logic [7:0] rs);
    logic [2:0]  reg_idx [5] = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_CAPSLOCK_CODE,
                                 REG_LSHIFT_CODE, REG_RSHIFT_CODE};
    logic [12:0] reg_val [5];
    reg_val = '{w, h, 13'(caps), 13'(ls), 13'(rs)};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= reg_idx[i];
      cfg_wdata <= reg_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    width_sel = w;
    height_sel = h;
    caps_sel = caps;
    lshift_sel = ls;
    rshift_sel = rs;
  endtask

  task automatic random_event();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      push_mouse(pick_coord(width_sel), pick_coord(height_sel), 3'($urandom_range(7)));
    else if (pick < 80)
      push_key(pick_scan(), pick_action());
    else if (pick < 92)
      push_event(OP_FRAME_END, noise_payload());
    else
      push_event(OP_CLEAR_PEND, noise_payload());
  endtask

  // Each phase opens with the coordinate extremes, then random events.
  task automatic run_phase(input int count);
    push_mouse(16'h8000, 16'h8000, 3'b000);
    push_mouse(16'h7fff, 16'h7fff, 3'b111);
    push_mouse(16'h0000, 16'h0000, 3'b101);
    for (int i = 0; i < count; i++) random_event();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= OP_MOUSE;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_SCREEN_WIDTH;
    cfg_wdata <= '0;
    width_sel = SCREEN_WIDTH_RST;
    height_sel = SCREEN_HEIGHT_RST;
    caps_sel = CAPSLOCK_CODE_RST;
    lshift_sel = LSHIFT_CODE_RST;
    rshift_sel = RSHIFT_CODE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events on the reset settings: clamping, clicks, frame flags,
    // caps lock and shift interplay, odd action codes and unmapped scancodes.
    push_mouse(16'h8000, 16'h8000, 3'b000);
    push_mouse(16'h7fff, 16'h7fff, 3'b111);
    push_mouse(16'h7fff, 16'h7fff, 3'b111);
    push_event(OP_FRAME_END, noise_payload());
    push_event(OP_CLEAR_PEND, noise_payload());
    push_key(8'd30, ACT_PRESSED);
    push_key(CAPSLOCK_CODE_RST, ACT_PRESSED);
    push_key(8'd30, ACT_HELD);
    push_key(8'd2, ACT_PRESSED);
    push_key(LSHIFT_CODE_RST, ACT_PRESSED);
    push_key(8'd30, ACT_PRESSED);
    push_key(8'd2, ACT_HELD);
    push_key(LSHIFT_CODE_RST, ACT_RELEASED);
    push_key(RSHIFT_CODE_RST, ACT_UNUSED);
    push_key(8'd2, ACT_PRESSED);
    push_key(CAPSLOCK_CODE_RST, ACT_HELD);
    push_key(CAPSLOCK_CODE_RST, ACT_PRESSED);
    push_key(8'd255, ACT_PRESSED);
    push_key(8'd89, ACT_PRESSED);
    push_key(8'd90, ACT_HELD);
    push_key(8'd0, ACT_PRESSED);
    push_key(8'd30, ACT_RELEASED);
    push_mouse(16'd5, 16'd6, 3'b010);
    push_mouse(16'd5, 16'd6, 3'b001);
    push_event(OP_FRAME_END, noise_payload());
    push_event(OP_FRAME_END, noise_payload());

    // Reset settings, no idling; a long result hold-off fills the block,
    // then the sender waits for everything to drain.
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    run_phase(PHASE_ITEMS / 2);
    hold_go <= 1'b1;
    random_event();
    hold_go <= 1'b0;
    for (int i = 0; i < 30; i++) random_event();
    wait_drained();
    for (int i = 0; i < PHASE_ITEMS / 2 - 31; i++) random_event();

    // Zero width and oversized height; sender idles.
    load_settings(13'd0, 13'd8191, 8'd0, 8'd255, 8'd0);
    send_gap_pct = 51;
    recv_stall_pct <= 0;
    run_phase(PHASE_ITEMS);

    // Full width, one-line height, caps lock on a letter key; receiver stalls.
    load_settings(13'd4096, 13'd1, 8'd30, 8'd16, 8'd17);
    send_gap_pct = 0;
    recv_stall_pct <= 51;
    run_phase(PHASE_ITEMS);

    // Narrowest width, full height, top and bottom scancodes; both sides idle.
    load_settings(13'd1, 13'd4096, 8'd255, 8'd0, 8'd255);
    send_gap_pct = 22;
    recv_stall_pct <= 22;
    run_phase(PHASE_ITEMS);

    // Random settings, idling mode changing in stretches.
    load_settings(13'($urandom), 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(0);
    for (int s = 0; s < 5; s++) begin
      case ($urandom_range(3))
        0: begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_gap_pct = 51; recv_stall_pct <= 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct <= 51; end
        default: begin send_gap_pct = 22; recv_stall_pct <= 22; end
      endcase
      for (int i = 0; i < PHASE_ITEMS / 5; i++) random_event();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
